### design/rce_pkg.sv
// ----------------------------------------------------------------------------
// Range coder encoder package
// Shared constants and the request struct passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package rce_pkg;
    localparam int FREQ_BITS_DEF = 16;
    localparam int FREQ_W        = 16;
    localparam int BOUND_W       = 32;
    localparam logic [BOUND_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [BOUND_W-1:0] TOP_LIMIT = 32'h0100_0000;
    localparam logic [7:0]         BYTE_MASK = 8'hFF;
    localparam int QDEPTH        = 2;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_FINISH = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [FREQ_W-1:0] cum_low;
        logic [FREQ_W-1:0] cum_top;
        logic [FREQ_W-1:0] total;
    } t_req;
endpackage
`default_nettype wire

### design/rce_front.sv
// ----------------------------------------------------------------------------
// Range coder front end
// Accepts requests, masks frequencies, drops zero-total encodes and queues.
// ----------------------------------------------------------------------------
`default_nettype none
module rce_front #(
    parameter int FREQ_BITS = rce_pkg::FREQ_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire                  i_mode,
    input  wire [15:0]           i_cum_low,
    input  wire [15:0]           i_cum_top,
    input  wire [15:0]           i_total,
    output logic                 o_q_valid,
    output rce_pkg::t_req        o_q_req,
    input  wire                  i_q_pop
);
    import rce_pkg::*;

    localparam logic [FREQ_W-1:0] FMASK =
        (FREQ_BITS >= FREQ_W) ? {FREQ_W{1'b1}} : FREQ_W'((1 << FREQ_BITS) - 1);

    t_req        r_q [QDEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_req        w_req;
    logic        w_push, w_acc;

    always_comb begin
        w_req.mode     = t_mode'(i_mode);
        w_req.cum_low  = i_cum_low & FMASK;
        w_req.cum_top  = i_cum_top & FMASK;
        w_req.total    = i_total & FMASK;
    end

    assign o_stall   = (r_cnt == 2'(QDEPTH));
    assign w_acc     = i_valid && !o_stall;
    // Encode requests with zero total have no effect and never enter the queue.
    assign w_push    = w_acc && (w_req.mode == MODE_FINISH || w_req.total != '0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end
endmodule
`default_nettype wire

### design/rce_div.sv
// ----------------------------------------------------------------------------
// Range coder divider
// Restoring divider, one quotient bit per cycle, 49-bit dividend by 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module rce_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [48:0] i_dividend,
    input  wire  [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import rce_pkg::*;

    logic [48:0] r_q;
    logic [16:0] r_rem;
    logic [15:0] r_d;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_trial;
    logic [16:0] w_sh;

    assign w_sh    = {r_rem[15:0], r_q[48]};
    assign w_trial = {1'b0, w_sh} - {2'b0, r_d};
    assign o_quot  = r_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd49;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[17]) begin
                r_rem <= w_trial[16:0];
                r_q   <= {r_q[47:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[47:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

### design/rce_back.sv
// ----------------------------------------------------------------------------
// Range coder back end
// Narrows the bounds with two divisions per encode request, or flushes the low
// bound on a finish request, and emits bytes through a holding register.
// ----------------------------------------------------------------------------
`default_nettype none
module rce_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_valid,
    input  wire rce_pkg::t_req i_q_req,
    output logic              o_q_pop,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last,
    output logic              o_idle
);
    import rce_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIVH, ST_DIVL, ST_EMIT, ST_FLUSH
    } t_state;

    t_state       r_state;
    logic [31:0]  r_low, r_high, r_qh;
    logic [32:0]  r_range;
    logic [48:0]  r_prod;
    logic [2:0]   r_n;
    t_req         r_req;
    logic         r_start;
    logic         w_done;
    logic [31:0]  w_quot;
    logic         w_out_free;
    logic [15:0]  w_mul_f;

    assign w_out_free = !o_valid || !i_stall;
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign o_idle     = (r_state == ST_IDLE) && !o_valid;
    assign w_mul_f    = (r_state == ST_MUL) ? r_req.cum_top : r_req.cum_low;

    rce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_prod),
        .i_divisor  (r_req.total),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= '0;
            r_high  <= ALL_ONES;
            o_valid <= 1'b0;
            r_start <= 1'b0;
            r_n     <= '0;
        end else begin
            r_start <= 1'b0;
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_req   <= i_q_req;
                        r_range <= {1'b0, r_high - r_low} + 33'd1;
                        r_n     <= '0;
                        r_state <= (i_q_req.mode == MODE_FINISH) ? ST_FLUSH : ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= r_range * w_mul_f;
                    r_start <= 1'b1;
                    r_state <= ST_DIVH;
                end
                ST_DIVH: begin
                    if (w_done) begin
                        r_qh    <= w_quot;
                        r_prod  <= r_range * w_mul_f;
                        r_start <= 1'b1;
                        r_state <= ST_DIVL;
                    end
                end
                ST_DIVL: begin
                    if (w_done) begin
                        r_high  <= r_low + r_qh - 32'd1;
                        r_low   <= r_low + w_quot;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if ((r_low ^ r_high) >= TOP_LIMIT || r_n == 3'd4) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        o_valid    <= 1'b1;
                        o_out_byte <= r_high[31:24];
                        o_last     <= 1'b0;
                        r_low      <= {r_low[23:0], 8'h00};
                        r_high     <= {r_high[23:0], BYTE_MASK};
                        r_n        <= r_n + 3'd1;
                    end
                end
                ST_FLUSH: begin
                    if (w_out_free) begin
                        o_valid    <= 1'b1;
                        o_out_byte <= r_low[31:24];
                        o_last     <= (r_n == 3'd3);
                        r_n        <= r_n + 3'd1;
                        if (r_n == 3'd3) begin
                            r_low   <= '0;
                            r_high  <= ALL_ONES;
                            r_state <= ST_IDLE;
                        end else begin
                            r_low   <= {r_low[23:0], 8'h00};
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/range_coder_encoder.sv
// ----------------------------------------------------------------------------
// Range coder encoder
// An encode request narrows the bounds with two 49-step divisions on one shared
// divider before any byte it emits; a finish request flushes the low bound directly.
// The back end holds one request at a time, and a two-entry queue in front takes
// further requests meanwhile. Synchronous active-low reset sets the low bound
// to zero and the high bound to all ones.
// ----------------------------------------------------------------------------
`default_nettype none
module range_coder_encoder #(
    parameter int FREQ_BITS = rce_pkg::FREQ_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_mode,
    input  wire  [15:0] i_cum_low,
    input  wire  [15:0] i_cum_top,
    input  wire  [15:0] i_total,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import rce_pkg::*;

    logic w_q_valid, w_q_pop, w_idle;
    t_req w_q_req;

    rce_front #(.FREQ_BITS(FREQ_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_cum_low  (i_cum_low),
        .i_cum_top  (i_cum_top),
        .i_total    (i_total),
        .o_q_valid  (w_q_valid),
        .o_q_req    (w_q_req),
        .i_q_pop    (w_q_pop)
    );

    rce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_req    (w_q_req),
        .o_q_pop    (w_q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_idle     (w_idle)
    );

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid) else $error("queue popped while empty");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled result changed");
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idle |-> !o_valid) else $error("idle while result pending");
endmodule
`default_nettype wire

### tb/tb_range_coder_encoder.sv
// ----------------------------------------------------------------------------
// Range coder encoder testbench
// Drives encode and finish requests with random idling on both channels and
// checks every emitted byte against a predictor of the 32-bit bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class byte_scoreboard;
    logic [31:0] bound_low;
    logic [31:0] bound_high;
    logic [8:0]  pending_bytes[$];
    int          mismatches;

    function new();
        bound_low  = 32'h0;
        bound_high = 32'hFFFF_FFFF;
        mismatches = 0;
    endfunction

    // Applies one accepted request to the bounds and queues the bytes it emits.
    function void note_request(rce_pkg::t_mode mode, logic [15:0] cl, logic [15:0] ch,
                               logic [15:0] tot);
        logic [32:0] span;
        logic [48:0] prod_h;
        logic [48:0] prod_l;
        logic [31:0] q_high;
        logic [31:0] q_low;
        int          n;
        if (mode == rce_pkg::MODE_FINISH) begin
            for (int i = 0; i < 4; i++)
                pending_bytes.push_back({bound_low[31 - 8*i -: 8], i == 3});
            bound_low  = 32'h0;
            bound_high = 32'hFFFF_FFFF;
            return;
        end
        if (tot == 0)
            return;
        span   = {1'b0, bound_high - bound_low} + 33'd1;
        prod_h = span * ch;
        prod_l = span * cl;
        q_high = 32'(prod_h / tot);
        q_low  = 32'(prod_l / tot);
        bound_high = bound_low + q_high - 32'd1;
        bound_low  = bound_low + q_low;
        n = 0;
        while ((bound_low ^ bound_high) < 32'h0100_0000 && n < 4) begin
            pending_bytes.push_back({bound_high[31:24], 1'b0});
            bound_low  = bound_low << 8;
            bound_high = (bound_high << 8) | 32'hFF;
            n++;
        end
    endfunction

    function bit check_byte(logic [7:0] b, logic lst, output string msg);
        logic [8:0] exp_b;
        if (pending_bytes.size() == 0) begin
            msg = $sformatf("unexpected byte %02h last %0b", b, lst);
            return 0;
        end
        exp_b = pending_bytes.pop_front();
        if (b !== exp_b[8:1] || lst !== exp_b[0]) begin
            msg = $sformatf("byte %02h last %0b, expected %02h last %0b",
                            b, lst, exp_b[8:1], exp_b[0]);
            return 0;
        end
        return 1;
    endfunction
endclass

module tb_range_coder_encoder;
    import rce_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_mode;
    logic [15:0] i_cum_low;
    logic [15:0] i_cum_top;
    logic [15:0] i_total;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_last;

    byte_scoreboard sb;
    bit  calm_phase;
    int  idle_cycles;
    int  requests_sent;
    int  bytes_seen;
    int  finishes_sent;

    range_coder_encoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_cum_low  (i_cum_low),
        .i_cum_top  (i_cum_top),
        .i_total    (i_total),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(string msg);
        sb.mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Output side: random stall bursts, checking each accepted byte.
    initial begin
        int burst;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm_phase && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 3);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            bytes_seen++;
            if (!sb.check_byte(o_out_byte, o_last, msg))
                report_mismatch(msg);
        end
    end

    // Watchdog on cycles with no accepted request or byte.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d bytes pending", sb.pending_bytes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(t_mode mode, logic [15:0] cl, logic [15:0] ch,
                                logic [15:0] tot);
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_cum_low  <= cl;
        i_cum_top  <= ch;
        i_total    <= tot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(mode, cl, ch, tot);
        requests_sent++;
        if (mode == MODE_FINISH)
            finishes_sent++;
    endtask

    task automatic send_symbol();
        logic [15:0] tot;
        logic [15:0] lo;
        logic [15:0] hi;
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 16) begin
            // Well-formed interval, mostly small models with the odd wide one.
            tot = (kind < 12) ? 16'($urandom_range(2, 300)) : 16'($urandom_range(2, 65535));
            lo  = 16'($urandom_range(0, tot - 1));
            hi  = 16'($urandom_range(lo + 1, tot));
        end else begin
            tot = 16'($urandom);
            lo  = 16'($urandom);
            hi  = 16'($urandom);
            if (kind == 19)
                tot = 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0001);
        end
        send_request(MODE_ENCODE, lo, hi, tot);
    endtask

    initial begin
        sb = new();
        calm_phase = 0;
        requests_sent = 0;
        finishes_sent = 0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_mode     <= MODE_ENCODE;
        i_cum_low  <= '0;
        i_cum_top  <= '0;
        i_total    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, zero total, crossed bounds, oversize quotients.
        send_request(MODE_ENCODE, 16'd0, 16'd1, 16'd1);
        send_request(MODE_ENCODE, 16'd0, 16'd1, 16'hFFFF);
        send_request(MODE_ENCODE, 16'hFFFE, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ENCODE, 16'd5, 16'd9, 16'd0);
        send_request(MODE_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ENCODE, 16'd0, 16'd0, 16'd7);
        send_request(MODE_ENCODE, 16'd3, 16'd4, 16'd10);
        send_request(MODE_FINISH, 16'd0, 16'd0, 16'd0);
        send_request(MODE_ENCODE, 16'hFFFF, 16'hFFFF, 16'd1);
        send_request(MODE_ENCODE, 16'hAAAA, 16'h5555, 16'h8000);
        send_request(MODE_ENCODE, 16'h1234, 16'h4321, 16'h0100);
        send_request(MODE_FINISH, 16'd1, 16'd2, 16'd3);
        send_request(MODE_ENCODE, 16'd0, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ENCODE, 16'd1, 16'd2, 16'd2);
        send_request(MODE_ENCODE, 16'd0, 16'd1, 16'd256);
        send_request(MODE_FINISH, 16'd0, 16'd0, 16'd0);

        // Hold off until every queued byte has drained.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);

        for (int n = 0; n < 430; n++) begin
            if (n == 380)
                calm_phase = 1;
            if ($urandom_range(0, 24) == 0)
                send_request(MODE_FINISH, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_symbol();
        end
        send_request(MODE_FINISH, 16'd0, 16'd0, 16'd0);
        i_valid <= 1'b0;

        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("Covered %0d requests (%0d finishes) and %0d checked bytes.",
                 requests_sent, finishes_sent, bytes_seen);
        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
